// ===== rtl/mono_bitmap_column_blitter_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the monochrome bitmap column blitter
// Immediate-style wrappers around concurrent assertions clocked by clk and
// disabled while rst_n is low. Empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MONO_BITMAP_COLUMN_BLITTER_TOP_ASSERT_SVH
`define MONO_BITMAP_COLUMN_BLITTER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define MBCB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mbcb assertion failed");
// next-cycle implication
`define MBCB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mbcb assertion failed");
`else
`define MBCB_ASSERT_IMP(lbl, ante, cons)
`define MBCB_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/mbcb_pkg.sv =====
// ----------------------------------------------------------------------------
// mbcb_pkg
// Types and constants shared by the bitmap column blitter modules.
// ----------------------------------------------------------------------------
package mbcb_pkg;

  localparam int unsigned SCREEN_MAX = 1024;
  localparam int unsigned COLOR_BITS = 16;
  localparam logic [15:0] COLOR_MASK = 16'(((64'd1 << COLOR_BITS) - 64'd1) & 64'hFFFF);
  localparam logic [10:0] SCREEN_MAX_DIM = 11'(SCREEN_MAX);
  localparam int unsigned BITS_PER_BYTE = 8;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_SCREEN_WIDTH  = 2'd0,
    REG_SCREEN_HEIGHT = 2'd1,
    REG_FG_COLOR      = 2'd2,
    REG_BG_COLOR      = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic       first_byte;
    logic [9:0] origin_x;
    logic [9:0] origin_y;
    logic [7:0] image_height;
    logic       bg_fill;
    logic [7:0] image_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [9:0]  pixel_x;
    logic [9:0]  pixel_y;
    logic [15:0] pixel_color;
    logic        run_end;
  } out_item_t;

  // drawing position and image context
  typedef struct packed {
    logic [10:0] col;
    logic [9:0]  row;
    logic [9:0]  top;
    logic [7:0]  hgt;
    logic        bg;
    logic        fin;
  } blit_state_t;

  // one byte worth of pixel writes plus the state it leaves behind
  typedef struct packed {
    logic [7:0]  wr_mask;  // bit k: step k (MSB first) writes a pixel
    logic [7:0]  set_bits; // bit k: step k is a foreground pixel
    logic [9:0]  x;
    logic [9:0]  y0;       // row of step 0
    blit_state_t nxt;
  } step_res_t;

endpackage

// ===== rtl/mbcb_step.sv =====
// ----------------------------------------------------------------------------
// mbcb_step
// Expands one bitmap byte against the current drawing position: which of
// the eight steps write a pixel, and where the column/row goes next.
// ----------------------------------------------------------------------------
module mbcb_step (
  input  mbcb_pkg::in_item_t    item,
  input  mbcb_pkg::blit_state_t cur,
  input  logic [10:0]           scr_w,
  input  logic [10:0]           scr_h,
  output mbcb_pkg::step_res_t   res
);
  import mbcb_pkg::*;

  blit_state_t eff;
  logic [10:0] sw_eff;
  logic [10:0] sh_eff;
  logic [10:0] row_adv [BITS_PER_BYTE];
  logic [7:0]  col_end;
  logic [7:0]  alive;
  logic [7:0]  seq_bits;
  logic        ended;
  logic [10:0] col_inc;

  assign sw_eff = (scr_w > SCREEN_MAX_DIM) ? SCREEN_MAX_DIM : scr_w;
  assign sh_eff = (scr_h > SCREEN_MAX_DIM) ? SCREEN_MAX_DIM : scr_h;

  // a first byte reloads the context before drawing
  always_comb begin
    eff = cur;
    if (item.first_byte) begin
      eff.col = {1'b0, item.origin_x};
      eff.row = item.origin_y;
      eff.top = item.origin_y;
      eff.hgt = item.image_height;
      eff.bg  = item.bg_fill;
      eff.fin = 1'b0;
    end
  end

  // end-of-column test after each step, all evaluated side by side
  always_comb begin
    for (int k = 0; k < BITS_PER_BYTE; k++) begin
      row_adv[k]  = {1'b0, eff.row} + 11'(k + 1);
      col_end[k]  = (row_adv[k] >= sh_eff) ||
                    ((row_adv[k] - {1'b0, eff.top}) >= {3'b000, eff.hgt});
      seq_bits[k] = item.image_byte[BITS_PER_BYTE - 1 - k];
    end
    alive[0] = 1'b1;
    for (int k = 1; k < BITS_PER_BYTE; k++) begin
      alive[k] = alive[k-1] & ~col_end[k-1];
    end
  end

  assign ended   = |(alive & col_end);
  assign col_inc = eff.col + 11'd1;

  always_comb begin
    res.wr_mask  = eff.fin ? 8'h00 : (alive & (seq_bits | {8{eff.bg}}));
    res.set_bits = seq_bits;
    res.x        = eff.col[9:0];
    res.y0       = eff.row;
    res.nxt      = eff;
    if (!eff.fin) begin
      if (ended) begin
        res.nxt.row = eff.top;
        res.nxt.col = col_inc;
        res.nxt.fin = (col_inc >= sw_eff) | item.last_byte;
      end else begin
        res.nxt.row = row_adv[BITS_PER_BYTE-1][9:0];
        res.nxt.fin = item.last_byte;
      end
    end
  end

endmodule

// ===== rtl/mono_bitmap_column_blitter_top.sv =====
// ----------------------------------------------------------------------------
// mono_bitmap_column_blitter_top
// Turns column-major, MSB-first 1bpp bitmap bytes into pixel writes.
// ----------------------------------------------------------------------------
//  channel | ports                          | moves
//  --------+--------------------------------+------------------------------
//  input   | in_valid / in_ready / in_data  | one bitmap byte + image ctx
//  output  | out_valid / out_ready/out_data | one pixel write (x, y, color)
//  config  | cfg_we / cfg_index / cfg_wdata | register write, no wait
//
//  A byte is taken into the input register, expanded combinationally and
//  loaded into a pixel buffer, and its pixels leave one per cycle while
//  out_ready is high. A byte with writes holds the buffer until its last
//  pixel leaves; a byte with no writes passes without loading it. The next
//  byte is accepted while the buffer still drains, so the sustained rate is
//  set by the output port: one pixel per cycle. Reset (rst_n low, synchronous)
//  restores the config defaults and the idle state; nothing needs clearing afterwards.
// ----------------------------------------------------------------------------
`include "mono_bitmap_column_blitter_top_assert.svh"

module mono_bitmap_column_blitter_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mbcb_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mbcb_pkg::out_item_t  out_data,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_wdata
);
  import mbcb_pkg::*;

  // configuration registers
  logic [10:0] scr_w_r;
  logic [10:0] scr_h_r;
  logic [15:0] fg_r;
  logic [15:0] bg_r;

  // drawing context
  blit_state_t st_r;

  // input register
  logic     in_v_r;
  in_item_t in_r;

  // pixel buffer: one byte of pending writes
  logic [7:0] buf_mask_r;
  logic [7:0] buf_set_r;
  logic [9:0] buf_x_r;
  logic [9:0] buf_y_r;

  step_res_t  res;
  logic       buf_free;
  logic       advance;
  logic       buf_load;
  logic       out_fire;
  logic [2:0] sel;
  logic [7:0] mask_rest;

  mbcb_step u_step (
    .item  (in_r),
    .cur   (st_r),
    .scr_w (scr_w_r),
    .scr_h (scr_h_r),
    .res   (res)
  );

  // earliest pending step goes out first
  always_comb begin
    sel = 3'd0;
    for (int k = BITS_PER_BYTE - 1; k >= 0; k--) begin
      if (buf_mask_r[k]) begin
        sel = 3'(k);
      end
    end
  end

  assign mask_rest = buf_mask_r & (buf_mask_r - 8'd1);
  assign out_valid = |buf_mask_r;
  assign out_fire  = out_valid & out_ready;

  always_comb begin
    out_data.pixel_x     = buf_x_r;
    out_data.pixel_y     = buf_y_r + 10'(sel);
    out_data.pixel_color = (buf_set_r[sel] ? fg_r : bg_r) & COLOR_MASK;
    out_data.run_end     = (mask_rest == 8'h00);
  end

  // buffer can take a new byte when empty or when its last pixel leaves now
  assign buf_free = !out_valid || (out_ready && (mask_rest == 8'h00));
  assign advance  = in_v_r && ((res.wr_mask == 8'h00) || buf_free);
  assign buf_load = advance && (res.wr_mask != 8'h00);
  assign in_ready = !in_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_w_r <= 11'd240;
      scr_h_r <= 11'd320;
      fg_r    <= 16'hFFFF;
      bg_r    <= 16'h0000;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_SCREEN_WIDTH:  scr_w_r <= cfg_wdata[10:0];
        REG_SCREEN_HEIGHT: scr_h_r <= cfg_wdata[10:0];
        REG_FG_COLOR:      fg_r    <= cfg_wdata;
        REG_BG_COLOR:      bg_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r     <= 1'b0;
      buf_mask_r <= 8'h00;
      st_r       <= '{col: 11'd0, row: 10'd0, top: 10'd0, hgt: 8'd0,
                      bg: 1'b0, fin: 1'b1};
    end else begin
      if (in_ready) begin
        in_v_r <= in_valid;
      end
      if (advance) begin
        st_r <= res.nxt;
      end
      if (buf_load) begin
        buf_mask_r <= res.wr_mask;
      end else if (out_fire) begin
        buf_mask_r <= mask_rest;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_r <= in_data;
    end
    if (buf_load) begin
      buf_set_r <= res.set_bits;
      buf_x_r   <= res.x;
      buf_y_r   <= res.y0;
    end
  end

  // a byte never lands on top of pixels that are still waiting
  `MBCB_ASSERT_IMP(a_no_overwrite, out_valid && (mask_rest != 8'h00), !buf_load)
  // the last pixel of a byte empties the buffer unless a new byte loads
  `MBCB_ASSERT_NXT(a_run_end_drains, out_fire && out_data.run_end && !buf_load, !out_valid)
  // the row never climbs above the image top
  `MBCB_ASSERT_IMP(a_row_below_top, 1'b1, st_r.row >= st_r.top)

endmodule
